// ===== src/oaids_pkg.sv =====
// ----------------------------------------------------------------------------
// oaids_pkg
// Shared constants for the ordered array insert/delete/search block.
// ----------------------------------------------------------------------------
package oaids_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISS    = 2'd3;

endpackage

// ===== src/oaids_ram.sv =====
// ----------------------------------------------------------------------------
// oaids_ram
// Simple dual-port table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oaids_ram import oaids_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ordered_array_insert_delete_search.sv =====
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search
// Positional table of signed 32-bit words with insert, delete and search.
//
// A request transfers when start is high and busy is low. Each request gives
// exactly one result: out_strobe is high for one cycle with out_status,
// out_found_index and out_entry_count. The receiver cannot stall.
// Rejected requests, insert at the end and delete of the last entry are
// answered straight from idle, with no table walk. Insert at position p
// shifts entries p..n-1 up, delete at p shifts entries p+1..n-1 down, and a
// search walks up from index 0 until a hit or the end (an empty table
// misses without a walk). The table memory gives one read and one write
// per cycle, and the table is walked one entry a cycle.
// busy is low in the cycle the result is shown, so a new request can
// transfer then. Reset clears the count and control; table contents are
// not cleared, and entries above the count are never read.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search import oaids_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [ADDR_W-1:0]        out_found_index,
  output logic [CNT_W-1:0]         out_entry_count
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_DEL  = 4'b0100,
    S_SRCH = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [WORD_W-1:0]   val_r, val_nxt;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_r, pend_nxt;
  logic                strobe_r, strobe_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [ADDR_W-1:0]   index_r, index_nxt;
  logic [CNT_W-1:0]    count_r;

  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;

  logic [CNT_W-1:0]    cnt_m1;
  logic [ADDR_W-1:0]   last_idx;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign last_idx = cnt_m1[ADDR_W-1:0];

  oaids_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    issue_nxt  = issue_r;
    pend_nxt   = pend_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    index_nxt  = '0;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = in_value;
          case (in_operation)
            OP_INSERT: begin
              if (in_position > cnt_r) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_BAD_POS;
              end else if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
              end else if (in_position == cnt_r) begin
                mem_we     = 1'b1;
                mem_waddr  = in_position[ADDR_W-1:0];
                mem_wdata  = in_value;
                cnt_nxt    = cnt_r + CNT_W'(1);
                strobe_nxt = 1'b1;
              end else begin
                pos_nxt    = in_position[ADDR_W-1:0];
                rd_idx_nxt = last_idx;
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_INS;
              end
            end
            OP_DELETE: begin
              if (in_position >= cnt_r) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_BAD_POS;
              end else if (in_position == cnt_m1) begin
                cnt_nxt    = cnt_m1;
                strobe_nxt = 1'b1;
              end else begin
                rd_idx_nxt = in_position[ADDR_W-1:0] + ADDR_W'(1);
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_MISS;
              end else begin
                rd_idx_nxt = '0;
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_SRCH;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = ST_BAD_POS;
            end
          endcase
        end
      end

      // shift up: read entry i, write it to i+1, walking down to pos
      S_INS: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          mem_re     = 1'b1;
          wr_idx_nxt = rd_idx_r + ADDR_W'(1);
          if (rd_idx_r == pos_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - ADDR_W'(1);
          end
        end
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (!issue_r && !pend_r) begin
          mem_we     = 1'b1;
          mem_waddr  = pos_r;
          mem_wdata  = val_r;
          cnt_nxt    = cnt_r + CNT_W'(1);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // shift down: read entry i, write it to i-1, walking up to the end
      S_DEL: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          mem_re     = 1'b1;
          wr_idx_nxt = rd_idx_r - ADDR_W'(1);
          if (rd_idx_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (!issue_r && !pend_r) begin
          cnt_nxt    = cnt_m1;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // wr_idx_r tracks the index of the word now in mem_rdata
      S_SRCH: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          mem_re     = 1'b1;
          wr_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
        if (pend_r && (mem_rdata == val_r)) begin
          issue_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          index_nxt  = wr_idx_r;
          state_nxt  = S_IDLE;
        end else if (!issue_r && !pend_r) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_MISS;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        issue_nxt = 1'b0;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      issue_r  <= 1'b0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      issue_r  <= issue_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
    count_r  <= cnt_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found_index = index_r;
  assign out_entry_count = count_r;

endmodule

// ===== dv/oaids_table_checker.sv =====
// ----------------------------------------------------------------------------
// oaids_table_checker
// Watches the request and result channels of the ordered array block, keeps
// its own copy of the table, predicts one reply per accepted request and
// compares every strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module oaids_table_checker import oaids_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     out_strobe,
  input  logic [1:0]               out_status,
  input  logic [ADDR_W-1:0]        out_found_index,
  input  logic [CNT_W-1:0]         out_entry_count,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] found_index;
    logic [CNT_W-1:0]  entry_count;
  } reply_t;

  logic signed [WORD_W-1:0] table_words [TABLE_DEPTH];
  int                       fill;
  reply_t                   expected_replies [$];
  int                       err_cnt = 0;
  int                       pend_cnt = 0;

  assign mismatches  = err_cnt;
  assign outstanding = pend_cnt;

  task automatic apply_request(input logic [1:0] op, input logic [CNT_W-1:0] pos,
                               input logic signed [WORD_W-1:0] val, output reply_t r);
    int i;
    r.status      = ST_BAD_POS;
    r.found_index = '0;
    case (op)
      OP_INSERT: begin
        if (int'(pos) > fill) begin
          r.status = ST_BAD_POS;
        end else if (fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = fill; i > int'(pos); i--) table_words[i] = table_words[i-1];
          table_words[pos[ADDR_W-1:0]] = val;
          fill++;
          r.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (int'(pos) >= fill) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = int'(pos); i + 1 < fill; i++) table_words[i] = table_words[i+1];
          fill--;
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        r.status = ST_MISS;
        for (i = 0; i < fill; i++) begin
          if (table_words[i] === val) begin
            r.status      = ST_OK;
            r.found_index = i[ADDR_W-1:0];
            break;
          end
        end
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.entry_count = fill[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      fill = 0;
      expected_replies.delete();
    end else begin
      if (out_strobe) begin
        got = '{out_status, out_found_index, out_entry_count};
        if (expected_replies.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                     $realtime, out_status, out_found_index, out_entry_count);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp status=%0d index=%0d count=%0d, got %0d/%0d/%0d",
                       $realtime, want.status, want.found_index, want.entry_count,
                       out_status, out_found_index, out_entry_count);
          end
        end
      end
      if (start && !busy) begin
        apply_request(in_operation, in_position, in_value, want);
        expected_replies.push_back(want);
      end
    end
    pend_cnt = expected_replies.size();
  end

endmodule

// ===== dv/tb_ordered_array_insert_delete_search.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_delete_search
// Regression for the ordered array block: a directed pass over edge cases,
// then phases of random requests that fill, churn and drain the table, with
// random gaps between transfers (none in burst phases). A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete_search import oaids_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH     = DEPTH_DEF;
  localparam int         ADDR_W    = $clog2(DEPTH);
  localparam int         CNT_W     = $clog2(DEPTH + 1);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         LIMIT     = 600000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_operation = '0;
  logic [CNT_W-1:0]         in_position = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic [ADDR_W-1:0]        out_found_index;
  logic [CNT_W-1:0]         out_entry_count;
  int                       mismatches;
  int                       outstanding;
  int                       cycles = 0;
  int                       fill = 0;

  ordered_array_insert_delete_search #(.TABLE_DEPTH(DEPTH)) dut (.*);

  oaids_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ordered_array_insert_delete_search regression: fail");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] pick_word(input int pool_pct);
    logic [WORD_W-1:0] pool [8];
    pool = '{32'h0, 32'hffffffff, 32'h1, 32'h2, 32'h7fffffff, 32'h80000000,
             32'h55555555, 32'haaaaaaaa};
    if ($urandom_range(0, 99) < pool_pct) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // leaves start high on return; the next call lowers it only if it idles
  task automatic issue(input logic [1:0] op, input int pos, input logic [WORD_W-1:0] val,
                       input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos[CNT_W-1:0];
    in_value     <= val;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT && pos <= fill && fill < DEPTH) fill++;
    else if (op == OP_DELETE && pos < fill) fill--;
  endtask

  task automatic random_request(input int kind, input int gap);
    int r;
    int ins_pct;
    int del_pct;
    int pos;
    r = $urandom_range(0, 99);
    ins_pct = (kind == 0) ? 70 : (kind == 1) ? 35 : 15;
    del_pct = (kind == 0) ? 10 : (kind == 1) ? 30 : 65;
    if (r < ins_pct) begin
      if ($urandom_range(0, 99) < 8) pos = $urandom_range(fill + 1, 127);
      else if ($urandom_range(0, 3) == 0) pos = ($urandom_range(0, 1) == 0) ? 0 : fill;
      else pos = $urandom_range(0, fill);
      issue(OP_INSERT, pos, pick_word(50), gap);
    end else if (r < ins_pct + del_pct) begin
      if (fill == 0 || $urandom_range(0, 99) < 8) pos = $urandom_range(fill, 127);
      else pos = $urandom_range(0, fill - 1);
      issue(OP_DELETE, pos, pick_word(20), gap);
    end else if (r < 95) begin
      issue(OP_SEARCH, $urandom_range(0, 127), pick_word(70), gap);
    end else begin
      issue(OP_UNUSED, $urandom_range(0, 127), pick_word(20), gap);
    end
  endtask

  initial begin
    int ph;
    int n;
    bit burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_SEARCH, 0, 32'h0, 0);
    issue(OP_DELETE, 0, 32'h0, 1);
    issue(OP_INSERT, 1, 32'h1, 0);
    issue(OP_INSERT, 0, 32'h80000000, 2);
    issue(OP_INSERT, 1, 32'h7fffffff, 0);
    issue(OP_INSERT, 0, 32'hffffffff, 0);
    issue(OP_INSERT, 1, 32'd5, 3);
    issue(OP_INSERT, 2, 32'd5, 0);
    issue(OP_SEARCH, 0, 32'd5, 0);
    issue(OP_SEARCH, 127, 32'h7fffffff, 1);
    issue(OP_SEARCH, 0, 32'hffffffff, 0);
    issue(OP_SEARCH, 0, 32'd123, 0);
    issue(OP_UNUSED, 127, 32'hffffffff, 0);
    issue(OP_INSERT, 127, 32'h0, 2);
    issue(OP_DELETE, fill, 32'h0, 0);
    issue(OP_DELETE, 1, 32'h0, 0);
    issue(OP_SEARCH, 64, 32'd5, 0);
    issue(OP_DELETE, fill - 1, 32'h0, 4);
    issue(OP_DELETE, 0, 32'h0, 0);
    issue(OP_INSERT, fill, 32'h0, 5);

    for (ph = 0; ph < 8; ph++) begin
      burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 150; n++)
        random_request(ph % 3, burst ? 0 : $urandom_range(0, 5));
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ordered_array_insert_delete_search regression: pass");
    end else begin
      $display("ordered_array_insert_delete_search regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/oaids_pkg.sv
src/oaids_ram.sv
src/ordered_array_insert_delete_search.sv
dv/oaids_table_checker.sv
dv/tb_ordered_array_insert_delete_search.sv
